FILE: hw/rtl/brq_pkg.sv
// Shared types and constants of the byte ring queue with marker search.
// Holds the action codes and the command and status groups between the
// controller and the datapath. Depends on nothing.
package brq_pkg;

    localparam int BYTE_W = 8;
    localparam int AMT_W  = 9;
    localparam int MARK_W = 16;
    localparam int CNT_W  = 9;
    localparam int ACT_W  = 3;

    typedef logic [ACT_W-1:0] action_t;

    localparam action_t ACT_PUSH    = 3'd0;
    localparam action_t ACT_POP     = 3'd1;
    localparam action_t ACT_PEEK    = 3'd2;
    localparam action_t ACT_DISCARD = 3'd3;
    localparam action_t ACT_CLEAR   = 3'd4;
    localparam action_t ACT_SEARCH  = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch a new request
        logic push;        // write at tail, advance tail
        logic pop;         // read at head, advance head
        logic peek;        // read at head plus offset
        logic discard;     // advance head by offset
        logic clear;       // return pointers and count to zero
        logic scan_start;  // read at head, arm the marker scan
        logic scan_step;   // examine one byte, issue the next read
        logic set_ok;      // mark the request successful
        logic take_rd;     // capture the read byte into the result
        logic load_out;    // move the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        action_t action;
        logic    full;
        logic    empty;
        logic    peek_ok;
        logic    discard_ok;
        logic    pair_ok;
        logic    scan_done;
        logic    out_free;
    } sts_t;

endpackage

FILE: hw/rtl/byte_ring_queue_with_marker_search.sv
// Top level of the byte ring queue with marker search.
// Joins the sequencer (brq_ctrl) and the datapath (brq_datapath).
// Depends on brq_pkg.
//
//   channel  | direction | handshake           | tuser       | tdata
//   ---------+-----------+---------------------+-------------+----------------------------
//   request  | in        | s_tvalid / s_tready | action[2:0] | push_byte, amount, marker
//   result   | out       | m_tvalid / m_tready | ok          | read_byte, span_length,
//            |           |                     |             | fill_count, is_empty, is_full
//
// Steps: push, discard, clear and unused actions pass from transfer through the
// execute and response states to the result; a successful pop or peek adds a read
// state (one registered read of the byte memory). A marker search adds a scan state
// that examines one byte per cycle, up to DEPTH, through the single read port of the memory.
// Reset clears pointers, count and handshake state; memory contents stay.
// A result held in the output register does not stop the next request
// transfer; a request whose result is ready waits only while the register
// is still occupied.
module byte_ring_queue_with_marker_search #(
    parameter int DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // push_byte[7:0], amount[16:8], marker[32:17], zero fill
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_byte[7:0], span_length[16:8], fill_count[25:17],
                                   // is_empty[26], is_full[27], zero fill
    output logic [0:0]  m_tuser    // ok[0]
);
    import brq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic              res_ok;
    logic [BYTE_W-1:0] res_read_byte;
    logic [CNT_W-1:0]  res_span;
    logic [CNT_W-1:0]  res_fill;
    logic              res_empty;
    logic              res_full;

    // Sequencer: accepts one request, then steps the datapath through it
    brq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: memory, pointers, scan and output register
    brq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_action       (s_tuser),
        .in_push_byte    (s_tdata[7:0]),
        .in_amount       (s_tdata[16:8]),
        .in_marker       (s_tdata[32:17]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_ok          (res_ok),
        .out_read_byte   (res_read_byte),
        .out_span_length (res_span),
        .out_fill_count  (res_fill),
        .out_is_empty    (res_empty),
        .out_is_full     (res_full)
    );

    // Pack the result transfer; upper bits of tdata stay zero
    assign m_tdata = {4'b0, res_full, res_empty, res_fill, res_span, res_read_byte};
    assign m_tuser = res_ok;

endmodule

FILE: hw/rtl/brq_ctrl.sv
// Sequencer of the byte ring queue: one request at a time.
// Decodes the action and drives the datapath commands.
// Depends on brq_pkg.
module brq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  brq_pkg::sts_t sts,
    output brq_pkg::cmd_t cmd
);
    import brq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
                unique case (sts.action)
                    ACT_PUSH:
                    begin
                        if (!sts.full)
                        begin
                            cmd.push   = 1'b1;
                            cmd.set_ok = 1'b1;
                        end
                    end
                    ACT_POP:
                    begin
                        if (!sts.empty)
                        begin
                            cmd.pop    = 1'b1;
                            cmd.set_ok = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    ACT_PEEK:
                    begin
                        if (sts.peek_ok)
                        begin
                            cmd.peek   = 1'b1;
                            cmd.set_ok = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    ACT_DISCARD:
                    begin
                        if (sts.discard_ok)
                        begin
                            cmd.discard = 1'b1;
                            cmd.set_ok  = 1'b1;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        cmd.set_ok = 1'b1;
                    end
                    ACT_SEARCH:
                    begin
                        if (sts.pair_ok)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_READ:
            begin
                cmd.take_rd = 1'b1;
                state_next  = ST_RESP;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/brq_datapath.sv
// Datapath of the byte ring queue: byte memory, head, tail, count,
// marker scan and the output register.
// Depends on brq_pkg.
module brq_datapath #(
    parameter int DEPTH = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  brq_pkg::cmd_t                cmd,
    output brq_pkg::sts_t                sts,
    input  brq_pkg::action_t             in_action,
    input  logic [brq_pkg::BYTE_W-1:0]   in_push_byte,
    input  logic [brq_pkg::AMT_W-1:0]    in_amount,
    input  logic [brq_pkg::MARK_W-1:0]   in_marker,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_ok,
    output logic [brq_pkg::BYTE_W-1:0]   out_read_byte,
    output logic [brq_pkg::CNT_W-1:0]    out_span_length,
    output logic [brq_pkg::CNT_W-1:0]    out_fill_count,
    output logic                         out_is_empty,
    output logic                         out_is_full
);
    import brq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > AMT_W) ? CW : AMT_W;
    localparam int SW = ((AW > AMT_W) ? AW : AMT_W) + 1;

    logic [BYTE_W-1:0] mem [DEPTH];

    action_t           action_reg;
    logic [BYTE_W-1:0] push_byte_reg;
    logic [AMT_W-1:0]  amount_reg;
    logic [MARK_W-1:0] marker_reg;

    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;

    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data_reg;

    logic [AW-1:0]     scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]     rx_idx_reg, rx_idx_next;
    logic [BYTE_W-1:0] prev_reg;

    logic              ok_res_reg;
    logic [BYTE_W-1:0] rd_res_reg;
    logic [CW-1:0]     span_res_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg;
    logic [BYTE_W-1:0] out_rd_reg;
    logic [CNT_W-1:0]  out_span_reg;
    logic [CNT_W-1:0]  out_fill_reg;
    logic              out_empty_reg;
    logic              out_full_reg;

    logic [XW-1:0]     amount_x;
    logic [XW-1:0]     count_x;
    logic              scan_hit;
    logic              scan_end;
    logic [AW-1:0]     peek_addr;

    // head plus an offset of at most DEPTH, wrapped once
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AMT_W-1:0] off);
        logic [SW-1:0] sum;
        begin
            sum = SW'(base) + SW'(off);
            if (sum >= SW'(DEPTH))
            begin
                sum = sum - SW'(DEPTH);
            end
            ring_add = sum[AW-1:0];
        end
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] ptr);
        begin
            if (ptr == AW'(DEPTH - 1))
            begin
                ring_inc = '0;
            end
            else
            begin
                ring_inc = ptr + AW'(1);
            end
        end
    endfunction

    assign amount_x  = XW'(amount_reg);
    assign count_x   = XW'(count_reg);
    assign peek_addr = ring_add(head_reg, amount_reg);

    assign scan_hit = (rx_idx_reg != '0) && ({prev_reg, rd_data_reg} == marker_reg);
    assign scan_end = (rx_idx_reg == count_reg - CW'(1));

    assign sts.action     = action_reg;
    assign sts.full       = (count_reg == CW'(DEPTH));
    assign sts.empty      = (count_reg == '0);
    assign sts.peek_ok    = (amount_x < count_x);
    assign sts.discard_ok = (amount_x <= count_x);
    assign sts.pair_ok    = (count_reg >= CW'(2));
    assign sts.scan_done  = scan_hit || scan_end;
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        priority if (cmd.pop || cmd.scan_start)
        begin
            rd_addr = head_reg;
        end
        else if (cmd.peek)
        begin
            rd_addr = peek_addr;
        end
        else
        begin
            rd_addr = scan_ptr_reg;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        priority if (cmd.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            tail_next  = ring_inc(tail_reg);
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            head_next  = ring_inc(head_reg);
            count_next = count_reg - CW'(1);
        end
        else if (cmd.discard)
        begin
            head_next  = peek_addr;
            count_next = count_reg - CW'(amount_reg);
        end
    end

    always_comb
    begin
        scan_ptr_next = scan_ptr_reg;
        rx_idx_next   = rx_idx_reg;
        priority if (cmd.scan_start)
        begin
            scan_ptr_next = ring_inc(head_reg);
            rx_idx_next   = '0;
        end
        else if (cmd.scan_step)
        begin
            scan_ptr_next = ring_inc(scan_ptr_reg);
            rx_idx_next   = rx_idx_reg + CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_ptr_reg  <= '0;
            rx_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_ptr_reg  <= scan_ptr_next;
            rx_idx_reg    <= rx_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= push_byte_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg    <= in_action;
            push_byte_reg <= in_push_byte;
            amount_reg    <= in_amount;
            marker_reg    <= in_marker;
            ok_res_reg    <= 1'b0;
            rd_res_reg    <= '0;
            span_res_reg  <= '0;
        end
        else
        begin
            if (cmd.set_ok)
            begin
                ok_res_reg <= 1'b1;
            end
            if (cmd.take_rd)
            begin
                rd_res_reg <= rd_data_reg;
            end
            if (cmd.scan_step && scan_hit)
            begin
                ok_res_reg   <= 1'b1;
                span_res_reg <= rx_idx_reg + CW'(1);
            end
        end
        if (cmd.scan_step)
        begin
            prev_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            out_ok_reg    <= ok_res_reg;
            out_rd_reg    <= rd_res_reg;
            out_span_reg  <= CNT_W'(span_res_reg);
            out_fill_reg  <= count_x[CNT_W-1:0];
            out_empty_reg <= (count_reg == '0);
            out_full_reg  <= (count_reg == CW'(DEPTH));
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_ok          = out_ok_reg;
    assign out_read_byte   = out_rd_reg;
    assign out_span_length = out_span_reg;
    assign out_fill_count  = out_fill_reg;
    assign out_is_empty    = out_empty_reg;
    assign out_is_full     = out_full_reg;

endmodule
